[rtl/itic_pkg.sv]
// shared constants, types and helper functions of the interval timer interrupt controller
`timescale 1ns / 1ps
`default_nettype none

package itic_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int PERIOD_WIDTH = 31;
    localparam int ELAPSED_WIDTH = 16;
    localparam int DATA_WIDTH   = 8;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COUNT_WIDTH-1:0] count_t;
    typedef logic [PERIOD_WIDTH-1:0] period_t;

    localparam count_t CNT_MAX = count_t'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
    localparam count_t CNT_MIN = count_t'(-(64'sd1 <<< (COUNT_WIDTH - 1)));
    localparam count_t BLANK_HOLD = count_t'(64'h0000_ffff);

    typedef enum logic [2:0] {
        OP_ADVANCE     = 3'd0,
        OP_ACK         = 3'd1,
        OP_WRITE_LEVEL = 3'd2,
        OP_WRITE_MASK  = 3'd3,
        OP_WRITE_SOUND = 3'd4
    } opcode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SERIAL_PERIOD = 3'd0,
        CFG_FRAME_PERIOD  = 3'd1,
        CFG_TOP_DELAY     = 3'd2,
        CFG_DISPLAY_LEN   = 3'd3,
        CFG_CLOCK_PERIOD  = 3'd4,
        CFG_SOUND_A       = 3'd5,
        CFG_SOUND_B       = 3'd6
    } cfg_index_t;

    localparam logic [2:0] VEC_SERIAL = 3'd0;
    localparam logic [2:0] VEC_VSYNC  = 3'd1;
    localparam logic [2:0] VEC_RTC    = 3'd2;
    localparam logic [2:0] VEC_SOUND  = 3'd4;

    localparam logic [1:0] PHASE_TOP     = 2'd1;
    localparam logic [1:0] PHASE_DISPLAY = 2'd2;
    localparam logic [1:0] PHASE_BOTTOM  = 2'd3;

    localparam period_t RST_SERIAL_PERIOD = 31'h7fff_ffff;
    localparam period_t RST_FRAME_PERIOD  = 31'd66666;
    localparam period_t RST_TOP_DELAY     = 31'd7113;
    localparam period_t RST_DISPLAY_LEN   = 31'd59523;
    localparam period_t RST_CLOCK_PERIOD  = 31'd6666;
    localparam period_t RST_SOUND_A       = 31'd73728;
    localparam period_t RST_SOUND_B       = 31'd1179648;

    // period clipped to the counter range
    function automatic count_t per_sat(input period_t p);
        logic [63:0] wide;
        begin
            wide = {33'd0, p};
            if (wide > 64'(CNT_MAX))
                per_sat = CNT_MAX;
            else
                per_sat = count_t'(wide);
        end
    endfunction

    function automatic count_t min2(input count_t a, input count_t b);
        begin
            min2 = (b < a) ? b : a;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/itic_if.sv]
// request and result channel interfaces of the interval timer interrupt controller
`timescale 1ns / 1ps
`default_nettype none

interface itic_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [15:0] elapsed_cycles;
    logic       serial_pending;
    logic [7:0] write_data;

    modport source (output valid, opcode, elapsed_cycles, serial_pending, write_data,
                    input ready);
    modport sink (input valid, opcode, elapsed_cycles, serial_pending, write_data,
                  output ready);
endinterface

interface itic_rsp_if;
    logic              valid;
    logic              ready;
    logic              irq_active;
    logic              vector_valid;
    logic [2:0]        vector_number;
    logic signed [31:0] next_event_cycles;
    logic [1:0]        retrace_phase;
    logic              frame_event;
    logic              sound_a_expired;
    logic              sound_b_expired;
    logic [1:0]        sound_flags;

    modport source (output valid, irq_active, vector_valid, vector_number,
                    next_event_cycles, retrace_phase, frame_event, sound_a_expired,
                    sound_b_expired, sound_flags,
                    input ready);
    modport sink (input valid, irq_active, vector_valid, vector_number,
                  next_event_cycles, retrace_phase, frame_event, sound_a_expired,
                  sound_b_expired, sound_flags,
                  output ready);
endinterface

`default_nettype wire

[rtl/itic_count_step.sv]
// saturating down-counter step with a single reload on underflow
`timescale 1ns / 1ps
`default_nettype none

module itic_count_step (
    input  wire itic_pkg::count_t              count,
    input  wire logic [itic_pkg::ELAPSED_WIDTH-1:0] elapsed,
    input  wire itic_pkg::count_t              period,
    input  wire logic                          run,
    output itic_pkg::count_t                   count_next,
    output logic                               expired
);
    import itic_pkg::*;

    logic signed [COUNT_WIDTH:0] diff;
    count_t dec;
    count_t reload;

    always_comb
    begin
        diff = {count[COUNT_WIDTH-1], count}
             - $signed({{(COUNT_WIDTH + 1 - ELAPSED_WIDTH){1'b0}}, elapsed});
        // only the low side can overflow here
        if (diff[COUNT_WIDTH] != diff[COUNT_WIDTH-1])
            dec = CNT_MIN;
        else
            dec = count_t'(diff[COUNT_WIDTH-1:0]);
        reload = dec + period;
        expired = run && dec[COUNT_WIDTH-1];
        if (!run)
            count_next = count;
        else if (expired)
            count_next = reload;
        else
            count_next = dec;
    end

endmodule

`default_nettype wire

[rtl/interval_timer_interrupt_controller_unit.sv]
// top level of the interval timer interrupt controller
`timescale 1ns / 1ps
`default_nettype none

// Interrupt controller built from reloading down-counters (serial, vsync, real-time
// clock, two sound timers) and a three-phase vertical retrace tracker. Each request
// is an advance, acknowledge, level write, mask write or sound control write (other
// opcodes change nothing) and yields exactly one result. A request is accepted every
// cycle while the result path moves; all counter updates and the acknowledge priority
// encoder are done in the accept cycle, the minimum over the counters is taken from
// the updated state as a result moves from s1_reg to out_reg. The user must write the
// period registers through cfg_we/cfg_index/cfg_data only while no request is in
// flight, which the block does not enforce; writing the serial period restarts its counter.
module interval_timer_interrupt_controller_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    itic_req_if.sink                                   req,
    itic_rsp_if.source                                 rsp,
    input  wire logic                                  cfg_we,
    input  wire logic [itic_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [itic_pkg::PERIOD_WIDTH-1:0]     cfg_data
);
    import itic_pkg::*;

    typedef struct packed {
        logic       irq_active;
        logic       vector_valid;
        logic [2:0] vector_number;
        logic [1:0] retrace_phase;
        logic       frame_event;
        logic       sound_a_expired;
        logic       sound_b_expired;
        logic [1:0] sound_flags;
    } status_t;

    // configuration
    period_t serial_period_reg, frame_period_reg, top_delay_reg, display_len_reg;
    period_t clock_period_reg, sound_a_period_reg, sound_b_period_reg;

    // counters and control state
    count_t serial_count_reg, frame_count_reg, retrace_count_reg, clock_count_reg;
    count_t sound_a_count_reg, sound_b_count_reg;
    count_t serial_count_next, frame_count_next, retrace_count_next, clock_count_next;
    count_t sound_a_count_next, sound_b_count_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] pending_reg, pending_next;
    logic [2:0] level_reg, level_next;
    logic [3:0] mask_reg, mask_next;
    logic [5:0] sound_ctrl_reg, sound_ctrl_next;
    logic       sound_level_reg, sound_level_next;

    // pipeline
    logic    s1_valid_reg;
    status_t s1_reg, s1_next;
    logic    out_valid_reg;
    status_t out_reg;
    count_t  nev_reg, nev_next;

    logic accept;
    logic s1_move;

    // counter steps
    count_t ser_step, frm_step, ret_step, clk_step, sa_step, sb_step;
    logic   ser_exp, frm_exp, ret_exp, clk_exp, sa_exp, sb_exp;
    logic   ret_run;
    logic [2:0] act_level;
    logic       sound_req;

    function automatic logic active_of(input logic [2:0] lvl, input logic [3:0] pend);
        begin
            active_of = (lvl >= 3'd1 && pend[0]) || (lvl >= 3'd2 && pend[1])
                     || (lvl >= 3'd3 && pend[2]) || (lvl >= 3'd5 && pend[3]);
        end
    endfunction

    assign ret_run = (phase_reg == PHASE_TOP) || (phase_reg == PHASE_DISPLAY);

    itic_count_step u_serial_step (
        .count(serial_count_reg), .elapsed(req.elapsed_cycles),
        .period(per_sat(serial_period_reg)), .run(1'b1),
        .count_next(ser_step), .expired(ser_exp)
    );

    itic_count_step u_frame_step (
        .count(frame_count_reg), .elapsed(req.elapsed_cycles),
        .period(per_sat(frame_period_reg)), .run(1'b1),
        .count_next(frm_step), .expired(frm_exp)
    );

    itic_count_step u_retrace_step (
        .count(retrace_count_reg), .elapsed(req.elapsed_cycles),
        .period(per_sat(display_len_reg)), .run(ret_run),
        .count_next(ret_step), .expired(ret_exp)
    );

    itic_count_step u_clock_step (
        .count(clock_count_reg), .elapsed(req.elapsed_cycles),
        .period(per_sat(clock_period_reg)), .run(1'b1),
        .count_next(clk_step), .expired(clk_exp)
    );

    itic_count_step u_sound_a_step (
        .count(sound_a_count_reg), .elapsed(req.elapsed_cycles),
        .period(per_sat(sound_a_period_reg)), .run(sound_ctrl_reg[0]),
        .count_next(sa_step), .expired(sa_exp)
    );

    itic_count_step u_sound_b_step (
        .count(sound_b_count_reg), .elapsed(req.elapsed_cycles),
        .period(per_sat(sound_b_period_reg)), .run(sound_ctrl_reg[1]),
        .count_next(sb_step), .expired(sb_exp)
    );

    // handshake
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    // next state for one request
    always_comb
    begin
        serial_count_next  = serial_count_reg;
        frame_count_next   = frame_count_reg;
        retrace_count_next = retrace_count_reg;
        clock_count_next   = clock_count_reg;
        sound_a_count_next = sound_a_count_reg;
        sound_b_count_next = sound_b_count_reg;
        phase_next         = phase_reg;
        pending_next       = pending_reg;
        level_next         = level_reg;
        mask_next          = mask_reg;
        sound_ctrl_next    = sound_ctrl_reg;
        sound_level_next   = sound_level_reg;
        act_level          = 3'd0;
        sound_req          = 1'b0;
        s1_next            = '0;

        if (accept)
        begin
            unique case (opcode_t'(req.opcode))
                OP_ADVANCE:
                begin
                    serial_count_next = ser_step;
                    if (ser_exp && req.serial_pending && mask_reg[0])
                        pending_next[0] = 1'b1;
                    frame_count_next = frm_step;
                    if (frm_exp)
                    begin
                        if (mask_reg[1])
                            pending_next[1] = 1'b1;
                        // frame restart puts the tracker back at top blanking
                        phase_next         = PHASE_TOP;
                        retrace_count_next = per_sat(top_delay_reg);
                    end
                    else if (phase_reg == PHASE_TOP)
                    begin
                        retrace_count_next = ret_step;
                        if (ret_exp)
                            phase_next = PHASE_DISPLAY;
                    end
                    else if (phase_reg == PHASE_DISPLAY)
                    begin
                        retrace_count_next = ret_step;
                        if (ret_exp)
                        begin
                            phase_next         = PHASE_BOTTOM;
                            retrace_count_next = BLANK_HOLD;
                        end
                    end
                    clock_count_next = clk_step;
                    if (clk_exp && mask_reg[2])
                        pending_next[2] = 1'b1;
                    sound_a_count_next = sa_step;
                    sound_b_count_next = sb_step;
                    if (sa_exp && sound_ctrl_reg[2])
                        sound_ctrl_next[4] = 1'b1;
                    if (sb_exp && sound_ctrl_reg[3])
                        sound_ctrl_next[5] = 1'b1;
                    // sound request on the rising edge of the combined level
                    sound_req = (|sound_ctrl_next[5:4]) && mask_reg[3];
                    if (!sound_level_reg && sound_req)
                        pending_next[3] = 1'b1;
                    sound_level_next = sound_req;
                    act_level = level_reg;
                    s1_next.frame_event     = frm_exp;
                    s1_next.sound_a_expired = sa_exp;
                    s1_next.sound_b_expired = sb_exp;
                end
                OP_ACK:
                begin
                    priority if (level_reg == 3'd0)
                    begin
                        s1_next.vector_valid = 1'b0;
                    end
                    else if (pending_reg[0])
                    begin
                        pending_next[0]       = 1'b0;
                        s1_next.vector_valid  = 1'b1;
                        s1_next.vector_number = VEC_SERIAL;
                    end
                    else if (level_reg >= 3'd2 && pending_reg[1])
                    begin
                        pending_next[1]       = 1'b0;
                        s1_next.vector_valid  = 1'b1;
                        s1_next.vector_number = VEC_VSYNC;
                    end
                    else if (level_reg >= 3'd3 && pending_reg[2])
                    begin
                        pending_next[2]       = 1'b0;
                        s1_next.vector_valid  = 1'b1;
                        s1_next.vector_number = VEC_RTC;
                    end
                    else if (level_reg >= 3'd5 && pending_reg[3])
                    begin
                        pending_next[3]       = 1'b0;
                        s1_next.vector_valid  = 1'b1;
                        s1_next.vector_number = VEC_SOUND;
                    end
                    else
                    begin
                        s1_next.vector_valid = 1'b0;
                    end
                    // active is judged before the level is dropped
                    act_level = level_reg;
                    if (s1_next.vector_valid)
                        level_next = 3'd0;
                end
                OP_WRITE_LEVEL:
                begin
                    level_next = req.write_data[2:0];
                    act_level  = level_next;
                end
                OP_WRITE_MASK:
                begin
                    mask_next = req.write_data[3:0];
                    act_level = level_reg;
                end
                OP_WRITE_SOUND:
                begin
                    if (!sound_ctrl_reg[0] && req.write_data[0])
                        sound_a_count_next = per_sat(sound_a_period_reg);
                    if (!sound_ctrl_reg[1] && req.write_data[1])
                        sound_b_count_next = per_sat(sound_b_period_reg);
                    sound_ctrl_next[3:0] = req.write_data[3:0];
                    if (req.write_data[4])
                        sound_ctrl_next[4] = 1'b0;
                    if (req.write_data[5])
                        sound_ctrl_next[5] = 1'b0;
                    act_level = level_reg;
                end
                default:
                begin
                    act_level = level_reg;
                end
            endcase
            s1_next.irq_active    = active_of(act_level, pending_next);
            s1_next.retrace_phase = phase_next;
            s1_next.sound_flags   = sound_ctrl_next[5:4];
        end

        if (cfg_we && cfg_index == CFG_SERIAL_PERIOD)
            serial_count_next = per_sat(cfg_data);
    end

    // minimum over running counters and the clock period, taken from the updated state
    count_t m_a, m_b, m_c, m_d;
    always_comb
    begin
        m_a = min2(per_sat(clock_period_reg), serial_count_reg);
        m_b = min2(frame_count_reg, ret_run ? retrace_count_reg : CNT_MAX);
        m_c = min2(clock_count_reg, sound_ctrl_reg[0] ? sound_a_count_reg : CNT_MAX);
        m_d = sound_ctrl_reg[1] ? sound_b_count_reg : CNT_MAX;
        nev_next = min2(min2(m_a, m_b), min2(m_c, m_d));
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_period_reg  <= RST_SERIAL_PERIOD;
            frame_period_reg   <= RST_FRAME_PERIOD;
            top_delay_reg      <= RST_TOP_DELAY;
            display_len_reg    <= RST_DISPLAY_LEN;
            clock_period_reg   <= RST_CLOCK_PERIOD;
            sound_a_period_reg <= RST_SOUND_A;
            sound_b_period_reg <= RST_SOUND_B;
            serial_count_reg   <= per_sat(RST_SERIAL_PERIOD);
            frame_count_reg    <= per_sat(RST_FRAME_PERIOD);
            retrace_count_reg  <= per_sat(RST_TOP_DELAY);
            clock_count_reg    <= per_sat(RST_CLOCK_PERIOD);
            sound_a_count_reg  <= per_sat(RST_SOUND_A);
            sound_b_count_reg  <= per_sat(RST_SOUND_B);
            phase_reg          <= PHASE_TOP;
            pending_reg        <= '0;
            level_reg          <= '0;
            mask_reg           <= '0;
            sound_ctrl_reg     <= '0;
            sound_level_reg    <= 1'b0;
        end
        else
        begin
            serial_count_reg   <= serial_count_next;
            frame_count_reg    <= frame_count_next;
            retrace_count_reg  <= retrace_count_next;
            clock_count_reg    <= clock_count_next;
            sound_a_count_reg  <= sound_a_count_next;
            sound_b_count_reg  <= sound_b_count_next;
            phase_reg          <= phase_next;
            pending_reg        <= pending_next;
            level_reg          <= level_next;
            mask_reg           <= mask_next;
            sound_ctrl_reg     <= sound_ctrl_next;
            sound_level_reg    <= sound_level_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SERIAL_PERIOD: serial_period_reg  <= cfg_data;
                    CFG_FRAME_PERIOD:  frame_period_reg   <= cfg_data;
                    CFG_TOP_DELAY:     top_delay_reg      <= cfg_data;
                    CFG_DISPLAY_LEN:   display_len_reg    <= cfg_data;
                    CFG_CLOCK_PERIOD:  clock_period_reg   <= cfg_data;
                    CFG_SOUND_A:       sound_a_period_reg <= cfg_data;
                    CFG_SOUND_B:       sound_b_period_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // result pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_move)
        begin
            out_reg <= s1_reg;
            nev_reg <= nev_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.irq_active        = out_reg.irq_active;
    assign rsp.vector_valid      = out_reg.vector_valid;
    assign rsp.vector_number     = out_reg.vector_number;
    assign rsp.next_event_cycles = 32'(nev_reg);
    assign rsp.retrace_phase     = out_reg.retrace_phase;
    assign rsp.frame_event       = out_reg.frame_event;
    assign rsp.sound_a_expired   = out_reg.sound_a_expired;
    assign rsp.sound_b_expired   = out_reg.sound_b_expired;
    assign rsp.sound_flags       = out_reg.sound_flags;

endmodule

`default_nettype wire

[test/interval_timer_interrupt_controller_unit_tb.sv]
// testbench of the interval timer interrupt controller: directed and random requests, checked results
`timescale 1ns / 1ps

module interval_timer_interrupt_controller_unit_tb;
    import itic_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 145;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_BURST     = 24;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam int FLAG_SERIAL = 0;
    localparam int FLAG_VSYNC  = 1;
    localparam int FLAG_RTC    = 2;
    localparam int FLAG_SOUND  = 3;

    localparam int LVL_SERIAL = 1;
    localparam int LVL_VSYNC  = 2;
    localparam int LVL_RTC    = 3;
    localparam int LVL_SOUND  = 5;

    localparam int SC_LOAD_A  = 0;
    localparam int SC_LOAD_B  = 1;
    localparam int SC_EN_A    = 2;
    localparam int SC_EN_B    = 3;
    localparam int SC_FLAG_A  = 4;
    localparam int SC_FLAG_B  = 5;

    localparam logic [7:0] SOUND_RUN_BOTH    = 8'h0f;
    localparam logic [7:0] SOUND_CLEAR_FLAGS = 8'h30;
    localparam logic [7:0] SOUND_ALL_BITS    = 8'h3f;

    localparam longint CNT_HI     = (longint'(1) <<< (COUNT_WIDTH - 1)) - 1;
    localparam longint CNT_LO     = -CNT_HI - 1;
    localparam longint PERIOD_TOP = 64'h7fff_ffff;
    localparam longint SERIAL_MIN = 100;
    localparam longint HOLD_COUNT = 64'h0000_ffff;

    typedef enum {PERIODS_SMALL, PERIODS_MIN, PERIODS_MAX, PERIODS_WIDE} period_mix_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] elapsed;
        logic        serial_pending;
        logic [7:0]  data;
    } timer_req_t;

    typedef struct packed {
        logic               irq_active;
        logic               vector_valid;
        logic [2:0]         vector_number;
        logic signed [31:0] next_event;
        logic [1:0]         phase;
        logic               frame_event;
        logic               a_expired;
        logic               b_expired;
        logic [1:0]         flags;
    } status_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [PERIOD_WIDTH-1:0]    cfg_data;

    itic_req_if req_if();
    itic_rsp_if rsp_if();

    interval_timer_interrupt_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    longint     serial_per, frame_per, top_per, disp_per, rtc_per, tone_a_per, tone_b_per;
    longint     ser_cnt, frm_cnt, rtr_cnt, rtc_cnt, tone_a_cnt, tone_b_cnt;
    logic [1:0] rtr_phase;
    logic [3:0] pend;
    logic [2:0] lvl;
    logic [3:0] en_mask;
    logic [5:0] snd_ctrl;
    logic       snd_lvl;

    timer_req_t request_q[$];
    status_t    expected_status[$];

    timer_req_t offered;
    int         burst_left;
    int         gap_left;
    int         gap_max = 0;
    int         stall_pct = 0;
    int         stall_left;
    int         hold_left;
    int         holds_asked = 0;
    int         holds_done;

    status_t    got;
    status_t    want;
    int         requests_sent = 0;
    int         results_seen = 0;
    int         bad_results = 0;
    int         vectors_served = 0;
    int         frame_events = 0;
    int         settings_run = 0;
    int         idle_cycles = 0;

    function automatic longint clip(input longint v);
        if (v > CNT_HI)
            return CNT_HI;
        if (v < CNT_LO)
            return CNT_LO;
        return v;
    endfunction

    function automatic logic irq_allowed();
        return (lvl >= LVL_SERIAL && pend[FLAG_SERIAL]) || (lvl >= LVL_VSYNC && pend[FLAG_VSYNC])
            || (lvl >= LVL_RTC && pend[FLAG_RTC]) || (lvl >= LVL_SOUND && pend[FLAG_SOUND]);
    endfunction

    function automatic longint soonest_event();
        longint m;
        m = rtc_per;
        if (ser_cnt < m)
            m = ser_cnt;
        if (frm_cnt < m)
            m = frm_cnt;
        if (rtr_phase != PHASE_BOTTOM && rtr_cnt < m)
            m = rtr_cnt;
        if (rtc_cnt < m)
            m = rtc_cnt;
        if (snd_ctrl[SC_LOAD_A] && tone_a_cnt < m)
            m = tone_a_cnt;
        if (snd_ctrl[SC_LOAD_B] && tone_b_cnt < m)
            m = tone_b_cnt;
        return m;
    endfunction

    // periods are kept clipped to the counter range
    function automatic void reset_model();
        serial_per = clip(RST_SERIAL_PERIOD);
        frame_per  = clip(RST_FRAME_PERIOD);
        top_per    = clip(RST_TOP_DELAY);
        disp_per   = clip(RST_DISPLAY_LEN);
        rtc_per    = clip(RST_CLOCK_PERIOD);
        tone_a_per = clip(RST_SOUND_A);
        tone_b_per = clip(RST_SOUND_B);
        ser_cnt    = serial_per;
        frm_cnt    = frame_per;
        rtr_cnt    = top_per;
        rtc_cnt    = rtc_per;
        tone_a_cnt = tone_a_per;
        tone_b_cnt = tone_b_per;
        rtr_phase  = PHASE_TOP;
        pend       = '0;
        lvl        = '0;
        en_mask    = '0;
        snd_ctrl   = '0;
        snd_lvl    = 1'b0;
    endfunction

    function automatic void apply_period(input cfg_index_t idx, input longint value);
        case (idx)
            CFG_SERIAL_PERIOD:
            begin
                serial_per = clip(value);
                ser_cnt = serial_per;
            end
            CFG_FRAME_PERIOD:  frame_per = clip(value);
            CFG_TOP_DELAY:     top_per = clip(value);
            CFG_DISPLAY_LEN:   disp_per = clip(value);
            CFG_CLOCK_PERIOD:  rtc_per = clip(value);
            CFG_SOUND_A:       tone_a_per = clip(value);
            CFG_SOUND_B:       tone_b_per = clip(value);
            default:
            begin
            end
        endcase
    endfunction

    function automatic void predict_status(input timer_req_t it);
        status_t s;
        longint  e;
        logic    new_lvl;
        s = '0;
        e = it.elapsed;
        case (it.op)
            OP_ADVANCE:
            begin
                ser_cnt = clip(ser_cnt - e);
                if (ser_cnt < 0)
                begin
                    ser_cnt = clip(ser_cnt + serial_per);
                    if (it.serial_pending && en_mask[FLAG_SERIAL])
                        pend[FLAG_SERIAL] = 1'b1;
                end
                frm_cnt = clip(frm_cnt - e);
                if (frm_cnt < 0)
                begin
                    frm_cnt = clip(frm_cnt + frame_per);
                    s.frame_event = 1'b1;
                    if (en_mask[FLAG_VSYNC])
                        pend[FLAG_VSYNC] = 1'b1;
                    rtr_phase = PHASE_TOP;
                    rtr_cnt = top_per + e;
                end
                if (rtr_phase == PHASE_TOP)
                begin
                    rtr_cnt = clip(rtr_cnt - e);
                    if (rtr_cnt < 0)
                    begin
                        rtr_phase = PHASE_DISPLAY;
                        rtr_cnt = clip(rtr_cnt + disp_per);
                    end
                end
                else if (rtr_phase == PHASE_DISPLAY)
                begin
                    rtr_cnt = clip(rtr_cnt - e);
                    if (rtr_cnt < 0)
                    begin
                        rtr_phase = PHASE_BOTTOM;
                        rtr_cnt = HOLD_COUNT;
                    end
                end
                rtc_cnt = clip(rtc_cnt - e);
                if (rtc_cnt < 0)
                begin
                    rtc_cnt = clip(rtc_cnt + rtc_per);
                    if (en_mask[FLAG_RTC])
                        pend[FLAG_RTC] = 1'b1;
                end
                if (snd_ctrl[SC_LOAD_A])
                begin
                    tone_a_cnt = clip(tone_a_cnt - e);
                    if (tone_a_cnt < 0)
                    begin
                        s.a_expired = 1'b1;
                        tone_a_cnt = clip(tone_a_cnt + tone_a_per);
                        if (snd_ctrl[SC_EN_A])
                            snd_ctrl[SC_FLAG_A] = 1'b1;
                    end
                end
                if (snd_ctrl[SC_LOAD_B])
                begin
                    tone_b_cnt = clip(tone_b_cnt - e);
                    if (tone_b_cnt < 0)
                    begin
                        s.b_expired = 1'b1;
                        tone_b_cnt = clip(tone_b_cnt + tone_b_per);
                        if (snd_ctrl[SC_EN_B])
                            snd_ctrl[SC_FLAG_B] = 1'b1;
                    end
                end
                // sound request on the rising edge of the combined level
                new_lvl = (snd_ctrl[SC_FLAG_B:SC_FLAG_A] != 2'b00) && en_mask[FLAG_SOUND];
                if (!snd_lvl && new_lvl)
                    pend[FLAG_SOUND] = 1'b1;
                snd_lvl = new_lvl;
            end
            OP_ACK:
            begin
                if (lvl >= LVL_SERIAL && pend[FLAG_SERIAL])
                begin
                    pend[FLAG_SERIAL] = 1'b0;
                    s.vector_valid = 1'b1;
                    s.vector_number = VEC_SERIAL;
                end
                else if (lvl >= LVL_VSYNC && pend[FLAG_VSYNC])
                begin
                    pend[FLAG_VSYNC] = 1'b0;
                    s.vector_valid = 1'b1;
                    s.vector_number = VEC_VSYNC;
                end
                else if (lvl >= LVL_RTC && pend[FLAG_RTC])
                begin
                    pend[FLAG_RTC] = 1'b0;
                    s.vector_valid = 1'b1;
                    s.vector_number = VEC_RTC;
                end
                else if (lvl >= LVL_SOUND && pend[FLAG_SOUND])
                begin
                    pend[FLAG_SOUND] = 1'b0;
                    s.vector_valid = 1'b1;
                    s.vector_number = VEC_SOUND;
                end
            end
            OP_WRITE_LEVEL: lvl = it.data[2:0];
            OP_WRITE_MASK:  en_mask = it.data[3:0];
            OP_WRITE_SOUND:
            begin
                if (!snd_ctrl[SC_LOAD_A] && it.data[SC_LOAD_A])
                    tone_a_cnt = tone_a_per;
                if (!snd_ctrl[SC_LOAD_B] && it.data[SC_LOAD_B])
                    tone_b_cnt = tone_b_per;
                snd_ctrl = {snd_ctrl[SC_FLAG_B:SC_FLAG_A], it.data[SC_EN_B:SC_LOAD_A]};
                if (it.data[SC_FLAG_A])
                    snd_ctrl[SC_FLAG_A] = 1'b0;
                if (it.data[SC_FLAG_B])
                    snd_ctrl[SC_FLAG_B] = 1'b0;
            end
            default:
            begin
            end
        endcase
        // active state is judged before an acknowledge drops the level
        s.irq_active = irq_allowed();
        if (s.vector_valid)
            lvl = '0;
        s.next_event = 32'(soonest_event());
        s.phase = rtr_phase;
        s.flags = snd_ctrl[SC_FLAG_B:SC_FLAG_A];
        expected_status.push_back(s);
    endfunction

    function automatic string fmt_status(input status_t s);
        return $sformatf("act=%0b vv=%0b vec=%0d next=%0d phase=%0d frame=%0b a=%0b b=%0b flags=%0b",
            s.irq_active, s.vector_valid, s.vector_number, s.next_event, s.phase,
            s.frame_event, s.a_expired, s.b_expired, s.flags);
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2, 3, 4: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic void push_req(input logic [2:0] op, input logic [15:0] e,
                                     input logic sp, input logic [7:0] d);
        timer_req_t it;
        it.op = op;
        it.elapsed = e;
        it.serial_pending = sp;
        it.data = d;
        request_q.push_back(it);
    endfunction

    function automatic void push_random_req();
        logic [2:0] op;
        if ($urandom_range(0, 99) < 6)
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        else
            op = 3'($urandom_range(OP_ADVANCE, OP_WRITE_SOUND));
        push_req(op, ($urandom_range(0, 1) != 0) ? pick_elapsed() : 16'($urandom()),
                 1'($urandom()), 8'($urandom()));
    endfunction

    // mask, level and sound setup followed by advances and acknowledges
    function automatic void push_service_round();
        logic [7:0] d;
        if ($urandom_range(0, 3) == 0)
        begin
            d = 8'($urandom());
            if ($urandom_range(0, 3) != 0)
                d[3:0] = 4'hf;
            push_req(OP_WRITE_MASK, 16'($urandom()), 1'($urandom()), d);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            d = 8'($urandom());
            if ($urandom_range(0, 1) != 0)
                d = d | SOUND_RUN_BOTH;
            push_req(OP_WRITE_SOUND, 16'($urandom()), 1'($urandom()), d);
        end
        push_req(OP_WRITE_LEVEL, 16'($urandom()), 1'($urandom()),
                 {5'($urandom()), 3'($urandom_range(1, 7))});
        repeat ($urandom_range(1, 4))
            push_req(OP_ADVANCE, pick_elapsed(), $urandom_range(0, 3) != 0, 8'($urandom()));
        repeat ($urandom_range(1, 3))
            push_req(OP_ACK, 16'($urandom()), 1'($urandom()), 8'($urandom()));
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid          <= 1'b0;
            req_if.opcode         <= '0;
            req_if.elapsed_cycles <= '0;
            req_if.serial_pending <= 1'b0;
            req_if.write_data     <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predict_status(offered);
                requests_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    offered = request_q.pop_front();
                    req_if.valid          <= 1'b1;
                    req_if.opcode         <= offered.op;
                    req_if.elapsed_cycles <= offered.elapsed;
                    req_if.serial_pending <= offered.serial_pending;
                    req_if.write_data     <= offered.data;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, MAX_BURST);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                    end
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls and long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            holds_done = 0;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done = holds_asked;
            hold_left = LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.irq_active    = rsp_if.irq_active;
            got.vector_valid  = rsp_if.vector_valid;
            got.vector_number = rsp_if.vector_number;
            got.next_event    = rsp_if.next_event_cycles;
            got.phase         = rsp_if.retrace_phase;
            got.frame_event   = rsp_if.frame_event;
            got.a_expired     = rsp_if.sound_a_expired;
            got.b_expired     = rsp_if.sound_b_expired;
            got.flags         = rsp_if.sound_flags;
            if (expected_status.size() == 0)
            begin
                if (bad_results < MAX_REPORTS)
                    $display("result with no request outstanding: %s", fmt_status(got));
                bad_results++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (got !== want)
                begin
                    if (bad_results < MAX_REPORTS)
                        $display("result %0d mismatch\n  expected %s\n  actual   %s",
                                 results_seen, fmt_status(want), fmt_status(got));
                    bad_results++;
                end
                results_seen++;
                if (want.vector_valid)
                    vectors_served++;
                if (want.frame_event)
                    frame_events++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_period(input cfg_index_t idx, input longint value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[PERIOD_WIDTH-1:0];
        apply_period(idx, value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_periods(input period_mix_t mix);
        case (mix)
            PERIODS_SMALL:
            begin
                write_period(CFG_SERIAL_PERIOD, $urandom_range(SERIAL_MIN, 3000));
                write_period(CFG_FRAME_PERIOD, $urandom_range(2000, 20000));
                write_period(CFG_TOP_DELAY, $urandom_range(0, 3000));
                write_period(CFG_DISPLAY_LEN, $urandom_range(0, 15000));
                write_period(CFG_CLOCK_PERIOD, $urandom_range(1, 5000));
                write_period(CFG_SOUND_A, $urandom_range(1, 8000));
                write_period(CFG_SOUND_B, $urandom_range(1, 30000));
            end
            PERIODS_MIN:
            begin
                write_period(CFG_SERIAL_PERIOD, SERIAL_MIN);
                write_period(CFG_FRAME_PERIOD, 1);
                write_period(CFG_TOP_DELAY, 0);
                write_period(CFG_DISPLAY_LEN, 0);
                write_period(CFG_CLOCK_PERIOD, 1);
                write_period(CFG_SOUND_A, 1);
                write_period(CFG_SOUND_B, 1);
            end
            PERIODS_MAX:
            begin
                write_period(CFG_SERIAL_PERIOD, PERIOD_TOP);
                write_period(CFG_FRAME_PERIOD, PERIOD_TOP);
                write_period(CFG_TOP_DELAY, PERIOD_TOP);
                write_period(CFG_DISPLAY_LEN, PERIOD_TOP);
                write_period(CFG_CLOCK_PERIOD, PERIOD_TOP);
                write_period(CFG_SOUND_A, PERIOD_TOP);
                write_period(CFG_SOUND_B, PERIOD_TOP);
            end
            default:
            begin
                write_period(CFG_SERIAL_PERIOD, $urandom_range(SERIAL_MIN, PERIOD_TOP));
                write_period(CFG_FRAME_PERIOD, $urandom_range(1, PERIOD_TOP));
                write_period(CFG_TOP_DELAY, $urandom_range(0, PERIOD_TOP));
                write_period(CFG_DISPLAY_LEN, $urandom_range(0, PERIOD_TOP));
                write_period(CFG_CLOCK_PERIOD, $urandom_range(1, PERIOD_TOP));
                write_period(CFG_SOUND_A, $urandom_range(1, PERIOD_TOP));
                write_period(CFG_SOUND_B, $urandom_range(1, PERIOD_TOP));
            end
        endcase
        settings_run++;
    endtask

    task automatic drain();
        while (request_q.size() != 0 || req_if.valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic fill_random();
        while (request_q.size() < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                push_service_round();
            else
                push_random_req();
        end
    endtask

    task automatic run_phase(input period_mix_t mix, input int gaps, input int stalls,
                             input bit long_hold);
        program_periods(mix);
        @(posedge clk);
        gap_max   <= gaps;
        stall_pct <= stalls;
        fill_random();
        if (long_hold)
        begin
            @(posedge clk);
            holds_asked <= holds_asked + 1;
        end
        drain();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        settings_run = 1;

        // directed requests under the reset periods
        gap_max   <= 6;
        stall_pct <= 25;
        push_req(OP_ACK, 16'h0000, 1'b0, 8'h00);
        push_req(OP_UNUSED_FIRST, 16'hffff, 1'b1, 8'hff);
        push_req(OP_UNUSED_MID, 16'h5555, 1'b0, 8'haa);
        push_req(OP_UNUSED_LAST, 16'haaaa, 1'b1, 8'h55);
        push_req(OP_ADVANCE, 16'h0000, 1'b0, 8'h00);
        push_req(OP_WRITE_MASK, 16'h0000, 1'b0, 8'hff);
        push_req(OP_WRITE_LEVEL, 16'h0000, 1'b0, 8'hf8);
        push_req(OP_ACK, 16'h0000, 1'b0, 8'h00);
        push_req(OP_WRITE_LEVEL, 16'h0000, 1'b0, 8'hff);
        push_req(OP_WRITE_SOUND, 16'h0000, 1'b0, SOUND_RUN_BOTH);
        push_req(OP_ADVANCE, 16'hffff, 1'b1, 8'h00);
        push_req(OP_ADVANCE, 16'hffff, 1'b1, 8'hff);
        push_req(OP_ACK, 16'h0000, 1'b0, 8'h00);
        push_req(OP_WRITE_LEVEL, 16'h0000, 1'b0, 8'h07);
        push_req(OP_ACK, 16'h0000, 1'b0, 8'h00);
        push_req(OP_WRITE_LEVEL, 16'h0000, 1'b0, 8'h05);
        push_req(OP_ACK, 16'h0000, 1'b0, 8'h00);
        push_req(OP_ACK, 16'h0000, 1'b0, 8'h00);
        push_req(OP_WRITE_SOUND, 16'h0000, 1'b0, SOUND_CLEAR_FLAGS);
        push_req(OP_WRITE_SOUND, 16'h0000, 1'b0, SOUND_ALL_BITS);
        push_req(OP_ADVANCE, 16'hffff, 1'b0, 8'h00);
        push_req(OP_ADVANCE, 16'h8000, 1'b1, 8'h00);
        fill_random();
        drain();

        run_phase(PERIODS_SMALL, 0, 0, 1'b1);
        run_phase(PERIODS_MIN, 3, 50, 1'b0);
        run_phase(PERIODS_MAX, 0, 0, 1'b0);
        run_phase(PERIODS_SMALL, 8, 30, 1'b0);
        run_phase(PERIODS_WIDE, 2, 70, 1'b0);
        run_phase(PERIODS_SMALL, 5, 20, 1'b1);

        if (expected_status.size() != 0)
        begin
            $display("%0d results never arrived", expected_status.size());
            bad_results++;
        end
        $display("%0d requests under %0d period settings, %0d results compared",
                 requests_sent, settings_run, results_seen);
        $display("%0d vectors served, %0d frame events, %0d bad results",
                 vectors_served, frame_events, bad_results);
        if (bad_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/itic_pkg.sv
rtl/itic_if.sv
rtl/itic_count_step.sv
rtl/interval_timer_interrupt_controller_unit.sv
test/interval_timer_interrupt_controller_unit_tb.sv
